>>> rtl/sal_pkg.sv
// sal_pkg: operation and status codes, and the control bundle that the list
// controller hands to every storage cell. No dependencies.

package sal_pkg;

  // Wide enough for any list position or count up to 1024 entries
  localparam int unsigned AT_W = 11;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_SEARCH    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic            load;  // capture the leaf for the lookup tree
    logic            ins;   // open a slot at 'at', shifting the upper cells up
    logic            del;   // close the slot at 'at', shifting the upper cells down
    logic            srch;  // leaf flags a value match instead of a position match
    logic [AT_W-1:0] at;
    logic [AT_W-1:0] cnt;   // entry count before the transaction
  } cell_ctl_t;

endpackage

>>> rtl/sal_cell.sv
// sal_cell: one entry of the list. Takes its neighbour's word on a shift and
// registers a leaf (hit flag and word) for the lookup tree. Uses sal_pkg.

module sal_cell #(
  parameter int DW  = 32,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  sal_pkg::cell_ctl_t  ctl,
  input  logic [DW-1:0]       val,
  input  logic [DW-1:0]       left_in,
  input  logic [DW-1:0]       right_in,
  output logic [DW-1:0]       data_o,
  output logic                leaf_hit_o,
  output logic [DW-1:0]       leaf_data_o
);

  localparam logic [sal_pkg::AT_W-1:0] MY_IDX = sal_pkg::AT_W'(IDX);

  logic [DW-1:0] data_r;
  logic [DW-1:0] data_nxt;
  logic          leaf_hit_r;
  logic          leaf_hit_nxt;
  logic [DW-1:0] leaf_data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX > ctl.at) begin
        data_nxt = left_in;
      end else if (MY_IDX == ctl.at) begin
        data_nxt = val;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= ctl.at) begin
        data_nxt = right_in;
      end
    end
  end

  always_comb begin
    if (ctl.srch) begin
      leaf_hit_nxt = (MY_IDX < ctl.cnt) && (data_r == val);
    end else begin
      leaf_hit_nxt = (MY_IDX == ctl.at);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.load) begin
      leaf_hit_r  <= leaf_hit_nxt;
      leaf_data_r <= data_r;
    end
  end

  assign data_o      = data_r;
  assign leaf_hit_o  = leaf_hit_r;
  assign leaf_data_o = leaf_data_r;

endmodule

>>> rtl/sal_tree.sv
// sal_tree: registered priority tree that picks the lowest flagged leaf and
// its word, one level per cycle. Stand-alone; no package use.

module sal_tree #(
  parameter int LEAVES = 64,
  parameter int DW     = 32
) (
  input  logic                        clk,
  input  logic                        leaf_hit  [LEAVES],
  input  logic [DW-1:0]               leaf_data [LEAVES],
  output logic                        root_hit,
  output logic [$clog2(LEAVES)-1:0]   root_idx,
  output logic [DW-1:0]               root_data
);

  localparam int IW = $clog2(LEAVES);

  // Heap order: node 1 is the root, leaves sit at LEAVES .. 2*LEAVES-1
  logic          hit_w  [1:2*LEAVES-1];
  logic [IW-1:0] idx_w  [1:2*LEAVES-1];
  logic [DW-1:0] data_w [1:2*LEAVES-1];

  genvar g;
  generate
    for (g = 0; g < LEAVES; g++) begin : g_leaf
      assign hit_w[LEAVES+g]  = leaf_hit[g];
      assign idx_w[LEAVES+g]  = IW'(g);
      assign data_w[LEAVES+g] = leaf_data[g];
    end

    for (g = 1; g < LEAVES; g++) begin : g_node
      logic          hit_r;
      logic [IW-1:0] idx_r;
      logic [DW-1:0] data_r;

      // Lower index wins
      always_ff @(posedge clk) begin
        hit_r  <= hit_w[2*g] | hit_w[2*g+1];
        idx_r  <= hit_w[2*g] ? idx_w[2*g]  : idx_w[2*g+1];
        data_r <= hit_w[2*g] ? data_w[2*g] : data_w[2*g+1];
      end

      assign hit_w[g]  = hit_r;
      assign idx_w[g]  = idx_r;
      assign data_w[g] = data_r;
    end
  endgenerate

  assign root_hit  = hit_w[1];
  assign root_idx  = idx_w[1];
  assign root_data = data_w[1];

endmodule

>>> rtl/shift_array_list.sv
// Bounded ordered list of signed words: insert, delete and search.
// Depends on sal_pkg, sal_cell and sal_tree.
//
// Usage
//   Input channel (in_valid / in_stall): one request per transaction, made of
//   in_operation, in_position and in_item_value. Result channel (out_valid /
//   out_stall): exactly one result per request, in request order.
//   The list lives in a row of DEPTH cells; an insert or delete shifts every
//   cell above the chosen slot in the cycle the request is taken. Each cell
//   then offers a leaf (position match for a delete, value match for a
//   search) to a registered priority tree of log2(DEPTH) levels, which
//   returns the removed word or the lowest matching index.
//   A result passes from the cell leaf registers through each tree level
//   to the output register. One request is in flight at a time, so a new
//   request is taken only once the previous result has left the tree.
//   in_stall is high while a request is in flight. A finished result sits in
//   the output register, so the next request is taken while out_stall holds
//   that result; a second result waits in the tree until the first is taken.
//   Reset empties the list (count to zero) and drops any pending result;
//   the stored words need no clearing since only entries below the count are
//   ever read.

module shift_array_list #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_item_value,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_value,
  output logic [5:0]  out_found_index,
  output logic [6:0]  out_entry_count,
  output logic        out_is_full,
  output logic        out_is_empty
);

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int LEVELS = $clog2(DEPTH);
  localparam int LEAVES = 1 << LEVELS;
  localparam int IW     = LEVELS;
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam int AW     = sal_pkg::AT_W;

  localparam logic [CW-1:0]  CNT_FULL  = CW'(DEPTH);
  localparam logic [LVW-1:0] LVL_ROOT  = LVW'(LEVELS);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [LVW-1:0]        lvl_r, lvl_nxt;
  sal_pkg::op_t          op_r, op_nxt;
  sal_pkg::status_t      pre_status_r, pre_status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_status_r, out_status_nxt;
  logic [31:0]           out_value_r, out_value_nxt;
  logic [5:0]            out_index_r, out_index_nxt;
  logic [6:0]            out_count_r, out_count_nxt;
  logic                  out_full_r, out_full_nxt;
  logic                  out_empty_r, out_empty_nxt;

  logic                  in_accept;
  logic                  out_load;
  sal_pkg::op_t          op;
  logic                  is_ins, is_del, is_srch;
  logic [AW-1:0]         at_eff;
  logic [AW-1:0]         cnt_ext;
  sal_pkg::status_t      status_dec;
  logic                  do_ins, do_del;
  logic [DATA_WIDTH-1:0] wval;
  sal_pkg::cell_ctl_t    ctl;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] left_in   [DEPTH];
  logic [DATA_WIDTH-1:0] right_in  [DEPTH];
  logic                  leaf_hit  [LEAVES];
  logic [DATA_WIDTH-1:0] leaf_data [LEAVES];
  logic                  root_hit;
  logic [IW-1:0]         root_idx;
  logic [DATA_WIDTH-1:0] root_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign wval      = DATA_WIDTH'($signed(in_item_value));
  assign cnt_ext   = AW'(count_r);

  // Request decode against the current count
  always_comb begin
    op      = sal_pkg::op_t'(in_operation);
    is_ins  = op inside {sal_pkg::OP_INS_FIRST, sal_pkg::OP_INS_LAST, sal_pkg::OP_INS_AT};
    is_del  = op inside {sal_pkg::OP_DEL_FIRST, sal_pkg::OP_DEL_LAST, sal_pkg::OP_DEL_AT};
    is_srch = (op == sal_pkg::OP_SEARCH);

    case (op)
      sal_pkg::OP_INS_LAST: at_eff = cnt_ext;
      sal_pkg::OP_DEL_LAST: at_eff = (count_r == '0) ? '0 : cnt_ext - 1'b1;
      sal_pkg::OP_INS_AT,
      sal_pkg::OP_DEL_AT:   at_eff = AW'(in_position);
      default:              at_eff = '0;
    endcase

    status_dec = sal_pkg::ST_OK;
    if (is_ins) begin
      if (count_r == CNT_FULL) begin
        status_dec = sal_pkg::ST_FULL;
      end else if (at_eff > cnt_ext) begin
        status_dec = sal_pkg::ST_BADIDX;
      end
    end else if (is_del) begin
      if (count_r == '0) begin
        status_dec = sal_pkg::ST_EMPTY;
      end else if (at_eff >= cnt_ext) begin
        status_dec = sal_pkg::ST_BADIDX;
      end
    end

    do_ins = in_accept & is_ins & (status_dec == sal_pkg::ST_OK);
    do_del = in_accept & is_del & (status_dec == sal_pkg::ST_OK);

    ctl.load = in_accept;
    ctl.ins  = do_ins;
    ctl.del  = do_del;
    ctl.srch = is_srch;
    ctl.at   = at_eff;
    ctl.cnt  = cnt_ext;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign left_in[gi] = wval;
      end else begin : g_mid_l
        assign left_in[gi] = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_in[gi] = cell_data[gi];
      end else begin : g_mid_r
        assign right_in[gi] = cell_data[gi+1];
      end

      sal_cell #(
        .DW  (DATA_WIDTH),
        .IDX (gi)
      ) u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .val         (wval),
        .left_in     (left_in[gi]),
        .right_in    (right_in[gi]),
        .data_o      (cell_data[gi]),
        .leaf_hit_o  (leaf_hit[gi]),
        .leaf_data_o (leaf_data[gi])
      );
    end

    for (gi = DEPTH; gi < LEAVES; gi++) begin : g_pad
      assign leaf_hit[gi]  = 1'b0;
      assign leaf_data[gi] = '0;
    end
  endgenerate

  sal_tree #(
    .LEAVES (LEAVES),
    .DW     (DATA_WIDTH)
  ) u_tree (
    .clk       (clk),
    .leaf_hit  (leaf_hit),
    .leaf_data (leaf_data),
    .root_hit  (root_hit),
    .root_idx  (root_idx),
    .root_data (root_data)
  );

  assign out_load = (state_r == S_BUSY) && (lvl_r == LVL_ROOT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lvl_nxt        = lvl_r;
    op_nxt         = op_r;
    pre_status_nxt = pre_status_r;

    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_full_nxt   = out_full_r;
    out_empty_nxt  = out_empty_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt      = S_BUSY;
          lvl_nxt        = '0;
          op_nxt         = op;
          pre_status_nxt = status_dec;
          if (do_ins) begin
            count_nxt = count_r + 1'b1;
          end else if (do_del) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      S_BUSY: begin
        if (lvl_r != LVL_ROOT) begin
          lvl_nxt = lvl_r + 1'b1;
        end
        if (out_load) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = pre_status_r;
          out_value_nxt  = '0;
          out_index_nxt  = '0;
          if (op_r == sal_pkg::OP_SEARCH) begin
            if (root_hit) begin
              out_value_nxt = 32'($signed(root_data));
              out_index_nxt = 6'(root_idx);
            end else begin
              out_status_nxt = sal_pkg::ST_NOTFOUND;
            end
          end else if ((op_r inside {sal_pkg::OP_DEL_FIRST, sal_pkg::OP_DEL_LAST,
                                     sal_pkg::OP_DEL_AT}) &&
                       (pre_status_r == sal_pkg::ST_OK)) begin
            out_value_nxt = 32'($signed(root_data));
          end
          out_count_nxt = 7'(count_r);
          out_full_nxt  = (count_r == CNT_FULL);
          out_empty_nxt = (count_r == '0);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    pre_status_r <= pre_status_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_full_r   <= out_full_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_found_index  = out_index_r;
  assign out_entry_count  = out_count_r;
  assign out_is_full      = out_full_r;
  assign out_is_empty     = out_empty_r;

  // The count never runs past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("list count beyond capacity");

  // A committed insert grows the list by exactly one entry
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not advance the count");

  // A new result appears only once the tree root has settled
  a_out_after_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |->
      $past(state_r == S_BUSY && lvl_r == LVL_ROOT))
    else $error("result loaded before the lookup finished");

endmodule

>>> tb/shift_array_list_tb.sv
// Self-checking testbench for shift_array_list: a directed table, then random
// fill, drain and mixed phases, checked against the table's typed results or
// an in-bench list predictor. Depends on sal_pkg and shift_array_list.

module shift_array_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 64;
  localparam int ITEMS_TOTAL  = 1850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 700;
  localparam int PAUSE_AFTER  = 1200;
  localparam int MAX_PRINTS   = 40;

  // Undefined operation code: the block must leave the list alone
  localparam logic [2:0] OP_IGNORED = 3'd7;

  typedef struct packed {
    sal_pkg::status_t status;
    logic [31:0]      value;
    logic [5:0]       index;
    logic [6:0]       count;
    logic             full;
    logic             empty;
  } list_result_t;

  typedef struct {
    logic [2:0]   op;
    logic [6:0]   pos;
    logic [31:0]  val;
    bit           typed;
    list_result_t res;
  } dir_row_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [6:0]  in_position = '0;
  logic [31:0] in_item_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_result_value;
  logic [5:0]  out_found_index;
  logic [6:0]  out_entry_count;
  logic        out_is_full;
  logic        out_is_empty;

  // Predictor state: the list contents and its length
  logic [31:0]  list_words [DEPTH];
  int unsigned  list_len = 0;

  list_result_t replies_due [$];
  dir_row_t     dir_rows [$];
  list_result_t want_res;
  int           items_taken = 0;
  int           mismatch_count = 0;
  int           idle_cycles = 0;

  shift_array_list #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (32)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_found_index  (out_found_index),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

  always #1 clk = ~clk;

  function automatic list_result_t apply_request(input logic [2:0] op, input logic [6:0] pos,
                                                 input logic [31:0] val);
    list_result_t r;
    int unsigned  at;
    int           i;
    r = '0;
    r.status = sal_pkg::ST_OK;
    case (op)
      sal_pkg::OP_INS_FIRST, sal_pkg::OP_INS_LAST, sal_pkg::OP_INS_AT: begin
        at = (op == sal_pkg::OP_INS_FIRST) ? 0 :
             (op == sal_pkg::OP_INS_LAST) ? list_len : pos;
        if (list_len >= DEPTH) r.status = sal_pkg::ST_FULL;
        else if (at > list_len) r.status = sal_pkg::ST_BADIDX;
        else begin
          for (i = list_len; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = val;
          list_len++;
        end
      end
      sal_pkg::OP_DEL_FIRST, sal_pkg::OP_DEL_LAST, sal_pkg::OP_DEL_AT: begin
        at = (op == sal_pkg::OP_DEL_FIRST) ? 0 :
             (op == sal_pkg::OP_DEL_LAST) ? ((list_len == 0) ? 0 : list_len - 1) : pos;
        if (list_len == 0) r.status = sal_pkg::ST_EMPTY;
        else if (at >= list_len) r.status = sal_pkg::ST_BADIDX;
        else begin
          r.value = list_words[at];
          for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      sal_pkg::OP_SEARCH: begin
        r.status = sal_pkg::ST_NOTFOUND;
        // walk downwards so the lowest matching index wins
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_words[i] == val) begin
            r.status = sal_pkg::ST_OK;
            r.value  = val;
            r.index  = 6'(i);
          end
        end
      end
      default: ;
    endcase
    r.count = 7'(list_len);
    r.full  = (list_len == DEPTH);
    r.empty = (list_len == 0);
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35 && list_len != 0) return list_words[$urandom_range(0, list_len - 1)];
    if (r < 65) return 32'($urandom_range(0, 8)) - 32'd4;
    if (r < 72) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [6:0] pick_position();
    if ($urandom_range(0, 99) < 80) return 7'($urandom_range(0, list_len));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic add_row(input bit typed, input logic [2:0] op, input logic [6:0] pos,
                         input logic [31:0] val, input sal_pkg::status_t st,
                         input logic [31:0] rv, input logic [5:0] fi, input logic [6:0] cnt);
    dir_row_t row;
    row.op  = op;
    row.pos = pos;
    row.val = val;
    row.typed = typed;
    row.res.status = st;
    row.res.value  = rv;
    row.res.index  = fi;
    row.res.count  = cnt;
    row.res.full   = (cnt == DEPTH);
    row.res.empty  = (cnt == 0);
    dir_rows.push_back(row);
  endtask

  task automatic send_request(input logic [2:0] op, input logic [6:0] pos, input logic [31:0] val,
                              input bit typed, input list_result_t typed_res);
    list_result_t pred;
    int           gap;
    int           r;
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_position   <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_request(op, pos, val);
    replies_due.push_back(typed ? typed_res : pred);
    items_taken++;
    r = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 9) : $urandom_range(15, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off new transactions until every outstanding result has been taken
  task automatic settle_list();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input phase_kind_t kind);
    int         extra;
    int         steps;
    int         cap;
    logic [2:0] op;
    extra = 0;
    steps = 0;
    cap = (kind == PH_MIXED) ? 60 : 200;
    while (items_taken < ITEMS_TOTAL && steps < cap && extra < 5) begin
      if (kind != PH_MIXED && $urandom_range(0, 99) < 80)
        op = (kind == PH_FILL) ?
             3'($urandom_range(sal_pkg::OP_INS_FIRST, sal_pkg::OP_INS_AT)) :
             3'($urandom_range(sal_pkg::OP_DEL_FIRST, sal_pkg::OP_DEL_AT));
      else
        op = 3'($urandom_range(0, 7));
      send_request(op, pick_position(), pick_value(), 1'b0, '0);
      steps++;
      // keep pushing a few transactions past the boundary
      if ((kind == PH_FILL && list_len == DEPTH) || (kind == PH_DRAIN && list_len == 0))
        extra++;
    end
  endtask

  initial begin : stimulus
    int          k;
    bit          paused;
    phase_kind_t kind;
    paused = 1'b0;
    // empty list: every delete reports empty, even with a wild index
    add_row(1, sal_pkg::OP_DEL_FIRST, 0,   0,             sal_pkg::ST_EMPTY,    0, 0, 0);
    add_row(1, sal_pkg::OP_DEL_LAST,  0,   0,             sal_pkg::ST_EMPTY,    0, 0, 0);
    add_row(1, sal_pkg::OP_DEL_AT,    0,   0,             sal_pkg::ST_EMPTY,    0, 0, 0);
    add_row(1, sal_pkg::OP_DEL_AT,    127, 0,             sal_pkg::ST_EMPTY,    0, 0, 0);
    add_row(1, sal_pkg::OP_SEARCH,    0,   0,             sal_pkg::ST_NOTFOUND, 0, 0, 0);
    add_row(1, sal_pkg::OP_INS_AT,    1,   5,             sal_pkg::ST_BADIDX,   0, 0, 0);
    add_row(1, OP_IGNORED,            3,   9,             sal_pkg::ST_OK,       0, 0, 0);
    // build [-1, max, min, 0]; insert at the count appends
    add_row(1, sal_pkg::OP_INS_AT,    0,   32'h7FFF_FFFF, sal_pkg::ST_OK,       0, 0, 1);
    add_row(1, sal_pkg::OP_INS_LAST,  0,   32'h8000_0000, sal_pkg::ST_OK,       0, 0, 2);
    add_row(1, sal_pkg::OP_INS_FIRST, 0,   32'hFFFF_FFFF, sal_pkg::ST_OK,       0, 0, 3);
    add_row(1, sal_pkg::OP_INS_AT,    3,   0,             sal_pkg::ST_OK,       0, 0, 4);
    add_row(0, sal_pkg::OP_INS_AT,    2,   32'hFFFF_FFFF, sal_pkg::ST_OK,       0, 0, 0);
    // duplicate -1: the lowest index must be reported
    add_row(1, sal_pkg::OP_SEARCH,    0,   32'hFFFF_FFFF, sal_pkg::ST_OK, 32'hFFFF_FFFF, 0, 5);
    add_row(0, sal_pkg::OP_SEARCH,    0,   0,             sal_pkg::ST_OK,       0, 0, 0);
    add_row(1, sal_pkg::OP_SEARCH,    0,   32'h1234_5678, sal_pkg::ST_NOTFOUND, 0, 0, 5);
    add_row(1, sal_pkg::OP_DEL_AT,    5,   0,             sal_pkg::ST_BADIDX,   0, 0, 5);
    add_row(1, sal_pkg::OP_INS_AT,    127, 1,             sal_pkg::ST_BADIDX,   0, 0, 5);
    add_row(1, sal_pkg::OP_INS_AT,    6,   1,             sal_pkg::ST_BADIDX,   0, 0, 5);
    add_row(0, sal_pkg::OP_DEL_AT,    2,   0,             sal_pkg::ST_OK,       0, 0, 0);
    add_row(0, sal_pkg::OP_DEL_LAST,  0,   0,             sal_pkg::ST_OK,       0, 0, 0);
    add_row(0, OP_IGNORED,            127, 32'hFFFF_FFFF, sal_pkg::ST_OK,       0, 0, 0);
    add_row(0, sal_pkg::OP_SEARCH,    0,   32'h8000_0000, sal_pkg::ST_OK,       0, 0, 0);
    add_row(0, sal_pkg::OP_DEL_FIRST, 0,   0,             sal_pkg::ST_OK,       0, 0, 0);
    add_row(0, sal_pkg::OP_DEL_AT,    1,   0,             sal_pkg::ST_OK,       0, 0, 0);
    add_row(0, sal_pkg::OP_DEL_LAST,  0,   0,             sal_pkg::ST_OK,       0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < dir_rows.size(); k++)
      send_request(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].val,
                   dir_rows[k].typed, dir_rows[k].res);
    settle_list();

    // random phases; fill phases run the list into full, drain phases into empty
    while (items_taken < ITEMS_TOTAL) begin
      if (!paused && items_taken >= PAUSE_AFTER) begin
        settle_list();
        paused = 1'b1;
      end
      kind = phase_kind_t'($urandom_range(0, 2));
      run_phase(kind);
    end

    settle_list();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && replies_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : receiver
    bit held;
    int r;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && items_taken >= HOLD_AFTER) begin
        // long hold-off: let the block back up and stall its input
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(50, 150)) @(posedge clk);
        end else if (r < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 94) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 9)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch("result with no request outstanding", out_result_value, 0);
      end else begin
        want_res = replies_due.pop_front();
        if (out_status !== want_res.status)
          report_mismatch("status", out_status, want_res.status);
        if (out_result_value !== want_res.value)
          report_mismatch("result_value", out_result_value, want_res.value);
        if (out_found_index !== want_res.index)
          report_mismatch("found_index", out_found_index, want_res.index);
        if (out_entry_count !== want_res.count)
          report_mismatch("entry_count", out_entry_count, want_res.count);
        if (out_is_full !== want_res.full)
          report_mismatch("is_full", out_is_full, want_res.full);
        if (out_is_empty !== want_res.empty)
          report_mismatch("is_empty", out_is_empty, want_res.empty);
      end
    end
  end

  // Watchdog: count cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
